/* rtl/wgg_pkg.sv */
// ----------------------------------------------------------------------------
// Waypoint go-to-goal controller package
// Shared widths, angle constants, register indexes and the CORDIC arctangent
// table.
// ----------------------------------------------------------------------------
`default_nettype none

package wgg_pkg;

    localparam int ANG_W      = 29;
    localparam int CRD_IN_W   = 34;
    localparam int CRD_W      = 45;
    localparam int SQ_IN_W    = 36;
    localparam int DIST_W     = 18;
    localparam int NORM_BIT   = 40;
    localparam int FAST_BIT   = 32;
    localparam int FAST_SHIFT = 8;

    localparam logic signed [ANG_W-1:0] ANG_PI    = 29'sd52707179;
    localparam logic signed [ANG_W-1:0] ANG_LIMIT = 29'sd79020687;
    localparam logic signed [18:0]      HEAD_SCALE = 19'sd13107;
    localparam logic signed [15:0]      TGT_Y_RST  = -16'sd819;

    localparam logic [1:0] REG_LIN_GAIN  = 2'd0;
    localparam logic [1:0] REG_HEAD_GAIN = 2'd1;
    localparam logic [1:0] REG_TOL       = 2'd2;
    localparam logic [1:0] REG_ACTIVE    = 2'd3;

    function automatic logic [23:0] atan_entry(input logic [4:0] idx);
        logic [23:0] v;
        case (idx)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            5'd20:   v = 24'd16;
            5'd21:   v = 24'd8;
            5'd22:   v = 24'd4;
            5'd23:   v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/wgg_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wgg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/wgg_cordic.sv */
// ----------------------------------------------------------------------------
// Iterative CORDIC arctangent
// Quadrant fold, normalizing shifts and one rotation step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wgg_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [wgg_pkg::CRD_IN_W-1:0]   i_y,
    input  wire logic signed [wgg_pkg::CRD_IN_W-1:0]   i_x,
    output logic                                       o_done,
    output logic signed [wgg_pkg::ANG_W-1:0]           o_angle
);

    import wgg_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_NORM = 3'b010,
        C_ROT  = 3'b100
    } t_cstate;

    t_cstate                    r_state;
    logic signed [CRD_W-1:0]    r_x, r_y;
    logic [4:0]                 r_i;
    logic signed [CRD_W-1:0]    x_ext, y_ext, sh_x, sh_y;
    logic [CRD_W-1:0]           mag_x, mag_y;
    logic                       big, fast;
    logic signed [ANG_W-1:0]    tab;

    assign x_ext = {{(CRD_W-CRD_IN_W){i_x[CRD_IN_W-1]}}, i_x};
    assign y_ext = {{(CRD_W-CRD_IN_W){i_y[CRD_IN_W-1]}}, i_y};
    assign mag_x = r_x[CRD_W-1] ? unsigned'(-r_x) : unsigned'(r_x);
    assign mag_y = r_y[CRD_W-1] ? unsigned'(-r_y) : unsigned'(r_y);
    assign big   = (|mag_x[CRD_W-1:NORM_BIT]) || (|mag_y[CRD_W-1:NORM_BIT]);
    assign fast  = !(|mag_x[CRD_W-1:FAST_BIT]) && !(|mag_y[CRD_W-1:FAST_BIT]);
    assign sh_x  = r_x >>> r_i;
    assign sh_y  = r_y >>> r_i;
    assign tab   = signed'(ANG_W'(atan_entry(r_i)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= ((r_state == C_IDLE) && i_start && (i_x == '0) && (i_y == '0))
                   || ((r_state == C_ROT) && (r_i == 5'(STEPS - 1)));
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        if (i_x == '0 && i_y == '0) begin
                            o_angle <= '0;
                        end else if (i_x[CRD_IN_W-1]) begin
                            o_angle <= i_y[CRD_IN_W-1] ? -ANG_PI : ANG_PI;
                            r_x     <= -x_ext;
                            r_y     <= -y_ext;
                            r_state <= C_NORM;
                        end else begin
                            o_angle <= '0;
                            r_x     <= x_ext;
                            r_y     <= y_ext;
                            r_state <= C_NORM;
                        end
                    end
                end
                C_NORM: begin
                    r_i <= '0;
                    if (big) begin
                        r_state <= C_ROT;
                    end else if (fast) begin
                        r_x <= r_x <<< FAST_SHIFT;
                        r_y <= r_y <<< FAST_SHIFT;
                    end else begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end
                end
                C_ROT: begin
                    if (!r_y[CRD_W-1]) begin
                        r_x     <= r_x + sh_y;
                        r_y     <= r_y - sh_x;
                        o_angle <= o_angle + tab;
                    end else begin
                        r_x     <= r_x - sh_y;
                        r_y     <= r_y + sh_x;
                        o_angle <= o_angle - tab;
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(STEPS - 1)) begin
                        r_state <= C_IDLE;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/wgg_isqrt.sv */
// ----------------------------------------------------------------------------
// Iterative integer square root
// One result bit per cycle, floor of the square root.
// ----------------------------------------------------------------------------
`default_nettype none

module wgg_isqrt (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [wgg_pkg::SQ_IN_W-1:0]     i_value,
    output logic                                 o_done,
    output logic      [wgg_pkg::DIST_W-1:0]      o_root
);

    import wgg_pkg::*;

    logic                 r_busy;
    logic [SQ_IN_W-1:0]   r_v, r_res, r_bit;
    logic [SQ_IN_W-1:0]   trial, n_res;
    logic                 take;

    assign trial  = r_res + r_bit;
    assign take   = r_v >= trial;
    assign n_res  = take ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    assign o_root = DIST_W'(r_res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= !i_start && r_busy && r_bit[0];
            if (i_start) begin
                r_busy <= 1'b1;
                r_v    <= i_value;
                r_res  <= '0;
                r_bit  <= SQ_IN_W'(1) << (SQ_IN_W - 2);
            end else if (r_busy) begin
                if (take) begin
                    r_v <= r_v - trial;
                end
                r_res <= n_res;
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/waypoint_go_to_goal_controller.sv */
// ----------------------------------------------------------------------------
// Waypoint go-to-goal controller
// Turns a pose into forward and turn commands toward the current waypoint.
// ----------------------------------------------------------------------------
// Channel    Direction  Handshake                 Content
// s_axis     in         tvalid/tready             pose or table entry item
// m_axis     out        tvalid/tready             command item
// apb        in         psel/penable/pready       gains, tolerance, slot count
//
// A pose item runs six multiplies on one shared multiplier, two CORDIC passes with
// their normalizing shifts, the square root running beside the second pass,
// then three multiplies, or one multiply and a table reload on arrival. A zero
// vector ends its CORDIC pass at once. A table entry item writes the table from
// the idle state and gives no result. The next item is taken while a result
// still waits on m_axis, and a pose then holds until it is read.
// Reset is synchronous and marks every table slot as holding its reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_go_to_goal_controller #(
    parameter int TABLE_DEPTH  = 8,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pos_x, pos_y, quat_x, quat_y, quat_z, quat_w, entry_index, entry_x, entry_y
    input  wire logic [135:0] s_axis_tdata,
    // mode
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // linear_cmd, angular_cmd, reached, target_slot
    output logic [39:0]       m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    import wgg_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_PROD = 10'b0000000010,
        S_CRD1 = 10'b0000000100,
        S_CRD2 = 10'b0000001000,
        S_HERR = 10'b0000010000,
        S_AMUL = 10'b0000100000,
        S_LMUL = 10'b0001000000,
        S_LSAT = 10'b0010000000,
        S_LOAD = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } t_state;

    t_state                   r_state;
    logic                     r_tgt;
    logic [15:0]              r_lin_gain, r_head_gain;
    logic [14:0]              r_tol;
    logic [3:0]               r_active;
    logic signed [15:0]       r_px, r_py, r_qx, r_qy, r_qz, r_qw, r_tx, r_ty;
    logic [SLOT_W-1:0]        r_slot;
    logic [TABLE_DEPTH-1:0]   r_valid;
    logic [2:0]               r_k;
    logic signed [47:0]       r_prod;
    logic signed [32:0]       r_acc_a, r_acc_b;
    logic [SQ_IN_W-1:0]       r_ssq;
    logic signed [ANG_W-1:0]  r_yaw, r_d;
    logic signed [15:0]       r_ang;
    logic [14:0]              r_lin;
    logic                     r_reached;
    logic                     r_crd_start, r_crd_ok, r_sq_ok;
    logic                     r_out_valid;
    logic [39:0]              r_out_data;

    logic                     in_acc, cfg_wr;
    logic signed [16:0]       dx, dy;
    logic signed [28:0]       mul_a;
    logic signed [18:0]       mul_b;
    logic signed [47:0]       product;
    logic signed [CRD_IN_W-1:0] crd_y, crd_x;
    logic                     crd_done, sq_done;
    logic signed [ANG_W-1:0]  crd_angle, d_now, e_now;
    logic [DIST_W-1:0]        dist_val;
    logic                     d_big;
    logic [6:0]               nxt_wide;
    logic [SLOT_W-1:0]        nxt_slot;
    logic [31:0]              ram_rdata;
    logic signed [21:0]       ang_sh;
    logic [33:0]              lin_sh;
    logic                     tab_we;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign pready        = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        case (paddr[3:2])
            REG_LIN_GAIN:  prdata = {16'd0, r_lin_gain};
            REG_HEAD_GAIN: prdata = {16'd0, r_head_gain};
            REG_TOL:       prdata = {17'd0, r_tol};
            REG_ACTIVE:    prdata = {28'd0, r_active};
            default:       prdata = '0;
        endcase
    end

    assign dx = {r_tx[15], r_tx} - {r_px[15], r_px};
    assign dy = {r_ty[15], r_ty} - {r_py[15], r_py};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_PROD: begin
                case (r_k)
                    3'd0: begin mul_a = 29'(r_qx); mul_b = 19'(r_qy); end
                    3'd1: begin mul_a = 29'(r_qw); mul_b = 19'(r_qz); end
                    3'd2: begin mul_a = 29'(r_qy); mul_b = 19'(r_qy); end
                    3'd3: begin mul_a = 29'(r_qz); mul_b = 19'(r_qz); end
                    3'd4: begin mul_a = 29'(dx);   mul_b = 19'(dx);   end
                    3'd5: begin mul_a = 29'(dy);   mul_b = 19'(dy);   end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_HERR: begin
                mul_a = d_now;
                mul_b = HEAD_SCALE;
            end
            S_AMUL: begin
                mul_a = e_now;
                mul_b = signed'({3'd0, r_head_gain});
            end
            S_LMUL: begin
                mul_a = signed'({11'd0, dist_val});
                mul_b = signed'({3'd0, r_lin_gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = 48'(mul_a) * 48'(mul_b);

    assign crd_y = (r_state == S_CRD1) ? signed'({r_acc_a, 1'b0}) : CRD_IN_W'(dx);
    assign crd_x = (r_state == S_CRD1)
                 ? (signed'(CRD_IN_W'(1) << 28) - signed'({r_acc_b, 1'b0}))
                 : CRD_IN_W'(dy);

    wgg_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_crd_start),
        .i_y     (crd_y),
        .i_x     (crd_x),
        .o_done  (crd_done),
        .o_angle (crd_angle)
    );

    wgg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_crd_start && (r_state == S_CRD2)),
        .i_value (r_ssq),
        .o_done  (sq_done),
        .o_root  (dist_val)
    );

    assign d_now = -crd_angle - r_yaw;
    assign d_big = (r_d > ANG_LIMIT) || (r_d < -ANG_LIMIT);
    assign e_now = d_big ? ANG_W'(r_prod >>> 16) : -r_d;

    assign nxt_wide = 7'(r_slot) + 7'd1;
    assign nxt_slot = ((nxt_wide >= 7'(r_active)) || (32'(nxt_wide) >= TABLE_DEPTH))
                    ? '0 : SLOT_W'(nxt_wide);

    assign tab_we = in_acc && s_axis_tuser[0] && (32'(s_axis_tdata[98:96]) < TABLE_DEPTH);

    wgg_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (SLOT_W'(s_axis_tdata[98:96])),
        .i_wdata (s_axis_tdata[130:99]),
        .i_raddr (nxt_slot),
        .o_rdata (ram_rdata)
    );

    assign ang_sh = 22'(r_prod >>> 26);
    assign lin_sh = 34'(r_prod >>> 14);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lin_gain  <= 16'd4915;
            r_head_gain <= 16'd11469;
            r_tol       <= 15'd102;
            r_active    <= 4'd8;
            r_tx        <= '0;
            r_ty        <= TGT_Y_RST;
            r_slot      <= '0;
            r_valid     <= '0;
            r_crd_start <= 1'b0;
            r_crd_ok    <= 1'b0;
            r_sq_ok     <= 1'b0;
            r_tgt       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_crd_start <= ((r_state == S_PROD) && (r_k == 3'd6))
                        || ((r_state == S_CRD1) && crd_done);
            r_prod      <= product;
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_LIN_GAIN:  r_lin_gain  <= pwdata[15:0];
                    REG_HEAD_GAIN: r_head_gain <= pwdata[15:0];
                    REG_TOL:       r_tol       <= pwdata[14:0];
                    REG_ACTIVE:    r_active    <= pwdata[3:0];
                    default:       r_active    <= r_active;
                endcase
            end
            if (r_out_valid && m_axis_tready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (tab_we) begin
                            r_valid[SLOT_W'(s_axis_tdata[98:96])] <= 1'b1;
                        end
                        if (!s_axis_tuser[0]) begin
                            r_px    <= s_axis_tdata[15:0];
                            r_py    <= s_axis_tdata[31:16];
                            r_qx    <= s_axis_tdata[47:32];
                            r_qy    <= s_axis_tdata[63:48];
                            r_qz    <= s_axis_tdata[79:64];
                            r_qw    <= s_axis_tdata[95:80];
                            r_k     <= '0;
                            r_state <= S_PROD;
                        end
                    end
                end
                S_PROD: begin
                    r_k <= r_k + 3'd1;
                    case (r_k)
                        3'd1: r_acc_a <= 33'(r_prod);
                        3'd2: r_acc_a <= r_acc_a + 33'(r_prod);
                        3'd3: r_acc_b <= 33'(r_prod);
                        3'd4: r_acc_b <= r_acc_b + 33'(r_prod);
                        3'd5: r_ssq   <= SQ_IN_W'(r_prod);
                        3'd6: begin
                            r_ssq   <= r_ssq + SQ_IN_W'(r_prod);
                            r_state <= S_CRD1;
                        end
                        default: ;
                    endcase
                end
                S_CRD1: begin
                    if (crd_done) begin
                        r_yaw    <= crd_angle;
                        r_crd_ok <= 1'b0;
                        r_sq_ok  <= 1'b0;
                        r_state  <= S_CRD2;
                    end
                end
                S_CRD2: begin
                    if (crd_done && !r_crd_start) begin
                        r_crd_ok <= 1'b1;
                    end
                    if (sq_done) begin
                        r_sq_ok <= 1'b1;
                    end
                    if (r_crd_ok && r_sq_ok) begin
                        r_state <= S_HERR;
                    end
                end
                S_HERR: begin
                    r_d <= d_now;
                    if (32'(dist_val) < 32'(r_tol)) begin
                        r_slot    <= nxt_slot;
                        r_lin     <= '0;
                        r_ang     <= '0;
                        r_reached <= 1'b1;
                        r_tgt     <= 1'b1;
                        r_state   <= S_LOAD;
                    end else begin
                        r_reached <= 1'b0;
                        r_state   <= S_AMUL;
                    end
                end
                S_AMUL: r_state <= S_LMUL;
                S_LMUL: begin
                    if (ang_sh > 22'sd32767) begin
                        r_ang <= 16'sd32767;
                    end else if (ang_sh < -22'sd32768) begin
                        r_ang <= -16'sd32768;
                    end else begin
                        r_ang <= 16'(ang_sh);
                    end
                    r_state <= S_LSAT;
                end
                S_LSAT: begin
                    r_lin   <= (lin_sh > 34'd32767) ? 15'd32767 : 15'(lin_sh);
                    r_state <= S_FIN;
                end
                S_LOAD: begin
                    r_tgt <= 1'b0;
                    if (r_valid[r_slot]) begin
                        r_tx <= ram_rdata[15:0];
                        r_ty <= ram_rdata[31:16];
                    end else begin
                        r_tx <= '0;
                        r_ty <= TGT_Y_RST;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {5'd0, 3'(r_slot), r_reached, r_ang, r_lin};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_pose_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !s_axis_tuser[0]) |=> !s_axis_tready)
        else $error("input taken while a pose item is in progress");

    a_reached_zero_cmds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[31]) |-> (m_axis_tdata[30:0] == 31'd0))
        else $error("arrival result carries nonzero commands");

    a_entry_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser[0]) |=> !$rose(m_axis_tvalid))
        else $error("table entry item produced a result");

    a_load_after_arrival: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_tgt && r_reached))
        else $error("target reload without arrival");
`endif

endmodule

`default_nettype wire

/* sim/tb_waypoint_go_to_goal_controller.sv */
// ----------------------------------------------------------------------------
// Testbench for the waypoint go-to-goal controller
// Drives pose and table entry items, idling at random except in the last phase,
// computes the expected command item for every pose from a bit-exact model
// of the CORDIC heading, square root distance and gain stages, checks each
// result field by field, and changes the gains, tolerance and slot count between phases.
// ----------------------------------------------------------------------------
`default_nettype none

class wgg_scoreboard;
    typedef struct packed {
        logic [14:0] linear_cmd;
        logic [15:0] angular_cmd;
        logic        reached;
        logic [2:0]  target_slot;
    } t_cmd;

    t_cmd        pending[$];
    int          errors;
    longint      lin_gain, head_gain, tol, active;
    longint      tgt_x, tgt_y;
    int          slot;
    longint      tab_x[8];
    longint      tab_y[8];
    longint      atan_lut[16];

    function new();
        atan_lut = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
                     65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};
        lin_gain = 4915;
        head_gain = 11469;
        tol = 102;
        active = 8;
        tgt_x = 0;
        tgt_y = -819;
        slot = 0;
        for (int i = 0; i < 8; i++) begin
            tab_x[i] = 0;
            tab_y[i] = -819;
        end
        errors = 0;
    endfunction

    function void set_reg(int idx, longint v);
        case (idx)
            wgg_pkg::REG_LIN_GAIN:  lin_gain = v & 16'hFFFF;
            wgg_pkg::REG_HEAD_GAIN: head_gain = v & 16'hFFFF;
            wgg_pkg::REG_TOL:       tol = v & 15'h7FFF;
            wgg_pkg::REG_ACTIVE:    active = v & 4'hF;
            default: ;
        endcase
    endfunction

    function longint vec_angle(longint yv, longint xv);
        longint acc, nx, ny, ax, ay;
        acc = 0;
        if (yv == 0 && xv == 0)
            return 0;
        if (xv < 0) begin
            acc = (yv >= 0) ? 64'sd52707179 : -64'sd52707179;
            xv = -xv;
            yv = -yv;
        end
        forever begin
            ax = (xv < 0) ? -xv : xv;
            ay = (yv < 0) ? -yv : yv;
            if (ax >= (64'sd1 <<< 40) || ay >= (64'sd1 <<< 40))
                break;
            xv = xv * 2;
            yv = yv * 2;
        end
        for (int i = 0; i < 16; i++) begin
            if (yv >= 0) begin
                nx = xv + (yv >>> i);
                ny = yv - (xv >>> i);
                acc += atan_lut[i];
            end else begin
                nx = xv - (yv >>> i);
                ny = yv + (xv >>> i);
                acc -= atan_lut[i];
            end
            xv = nx;
            yv = ny;
        end
        return acc;
    endfunction

    function longint int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function void note_input(logic mode, logic [135:0] d);
        longint px, py, qx, qy, qz, qw, num, den, yaw, d_ang, e, dx, dy, dist_q, lin, ang;
        t_cmd r;
        if (mode) begin
            tab_x[d[98:96]] = longint'($signed(d[114:99]));
            tab_y[d[98:96]] = longint'($signed(d[130:115]));
            return;
        end
        px = longint'($signed(d[15:0]));
        py = longint'($signed(d[31:16]));
        qx = longint'($signed(d[47:32]));
        qy = longint'($signed(d[63:48]));
        qz = longint'($signed(d[79:64]));
        qw = longint'($signed(d[95:80]));
        num = 2 * (qx * qy + qw * qz);
        den = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
        yaw = vec_angle(num, den);
        dx = tgt_x - px;
        dy = tgt_y - py;
        d_ang = -vec_angle(dx, dy) - yaw;
        if (d_ang > 79020687 || d_ang < -79020687)
            e = (d_ang * 13107) >>> 16;
        else
            e = -d_ang;
        dist_q = int_sqrt(longint'(dx * dx + dy * dy));
        if (dist_q < tol) begin
            slot = slot + 1;
            if (slot >= active || slot >= 8)
                slot = 0;
            tgt_x = tab_x[slot];
            tgt_y = tab_y[slot];
            r.linear_cmd = '0;
            r.angular_cmd = '0;
            r.reached = 1'b1;
        end else begin
            lin = (lin_gain * dist_q) >>> 14;
            if (lin > 32767)
                lin = 32767;
            ang = (head_gain * e) >>> 26;
            if (ang > 32767)
                ang = 32767;
            if (ang < -32768)
                ang = -32768;
            r.linear_cmd = lin[14:0];
            r.angular_cmd = ang[15:0];
            r.reached = 1'b0;
        end
        r.target_slot = slot[2:0];
        pending.push_back(r);
    endfunction

    function void check_result(logic [39:0] d);
        t_cmd x;
        if (pending.size() == 0) begin
            $display("%0t: unexpected command item %h", $time, d);
            errors++;
            return;
        end
        x = pending.pop_front();
        if (d[14:0] !== x.linear_cmd) begin
            $display("%0t: linear_cmd expected %0d actual %0d", $time, x.linear_cmd, d[14:0]);
            errors++;
        end
        if (d[30:15] !== x.angular_cmd) begin
            $display("%0t: angular_cmd expected %0d actual %0d", $time,
                     $signed(x.angular_cmd), $signed(d[30:15]));
            errors++;
        end
        if (d[31] !== x.reached) begin
            $display("%0t: reached expected %0d actual %0d", $time, x.reached, d[31]);
            errors++;
        end
        if (d[34:32] !== x.target_slot) begin
            $display("%0t: target_slot expected %0d actual %0d", $time,
                     x.target_slot, d[34:32]);
            errors++;
        end
    endfunction
endclass

module tb_waypoint_go_to_goal_controller;
    import wgg_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    wgg_scoreboard cmd_board = new();
    bit            gaps_on = 1'b1;
    int            sink_hold = 0;

    waypoint_go_to_goal_controller dut (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #8000000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            cmd_board.check_result(m_axis_tdata);

    always @(negedge i_clk) begin
        if (!gaps_on) begin
            m_axis_tready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            sink_hold <= $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(logic mode, logic [135:0] d);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = mode;
        s_axis_tdata = d;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        cmd_board.note_input(mode, d);
        @(negedge i_clk);
    endtask

    task automatic send_pose(longint px, longint py, longint qx, longint qy,
                             longint qz, longint qw);
        logic [135:0] d;
        d = '0;
        d[15:0] = px[15:0];
        d[31:16] = py[15:0];
        d[47:32] = qx[15:0];
        d[63:48] = qy[15:0];
        d[79:64] = qz[15:0];
        d[95:80] = qw[15:0];
        d[130:96] = {$urandom(), 3'($urandom())};
        send_item(1'b0, d);
    endtask

    task automatic send_entry(int idx, longint ex, longint ey);
        logic [135:0] d;
        d = 136'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        d[98:96] = idx[2:0];
        d[114:99] = ex[15:0];
        d[130:115] = ey[15:0];
        d[135:131] = '0;
        send_item(1'b1, d);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (cmd_board.pending.size() != 0)
            @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, longint v);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = v[31:0];
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        cmd_board.set_reg(idx, v);
    endtask

    function automatic longint clip16(longint v);
        return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
    endfunction

    function automatic longint rand_q();
        case ($urandom_range(0, 7))
            0: return -16384;
            1: return 16384;
            2: return 0;
            default: return longint'($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    task automatic random_run(int count);
        longint span;
        for (int n = 0; n < count; n++) begin
            span = cmd_board.tol * 2 + 64;
            case ($urandom_range(0, 19))
                0, 1, 2:
                    send_entry($urandom_range(0, 7), $signed(16'($urandom())),
                               $signed(16'($urandom())));
                3, 4, 5:
                    send_pose($signed(16'($urandom())), $signed(16'($urandom())),
                              rand_q(), rand_q(), rand_q(), rand_q());
                default:
                    send_pose(clip16(cmd_board.tgt_x + $urandom_range(0, span) - span / 2),
                              clip16(cmd_board.tgt_y + $urandom_range(0, span) - span / 2),
                              rand_q(), rand_q(), rand_q(), rand_q());
            endcase
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed items at reset settings.
        send_pose(0, -819, 0, 0, 0, 16384);
        send_pose(32767, 32767, 16384, 16384, 16384, 16384);
        send_pose(-32768, -32768, -16384, -16384, -16384, -16384);
        send_pose(-32768, 32767, 0, 0, 16384, 0);
        send_pose(32767, -32768, 0, 0, -16384, 0);
        send_pose(100, 0, 0, 0, 0, 0);
        send_pose(-5000, 100, 0, 0, 16384, 1);
        send_entry(0, 32767, -32768);
        send_entry(7, -32768, 32767);
        send_entry(1, 1000, 2000);
        send_entry(2, 0, 0);
        send_pose(1, -820, 0, 0, 0, 16384);
        send_pose(1000, 2000, 0, 0, 0, 16384);
        send_pose(0, 0, 0, 0, 0, 16384);
        send_pose(0, 0, 3000, -7000, 12000, 16384);
        send_pose(10, 10, 16384, 0, 0, 0);
        drain();
        random_run(110);
        drain();

        write_reg(REG_TOL, 32767);
        write_reg(REG_ACTIVE, 1);
        random_run(80);
        drain();

        write_reg(REG_LIN_GAIN, 65535);
        write_reg(REG_HEAD_GAIN, 65535);
        write_reg(REG_TOL, 0);
        write_reg(REG_ACTIVE, 8);
        random_run(90);
        drain();

        write_reg(REG_LIN_GAIN, 0);
        write_reg(REG_HEAD_GAIN, 0);
        write_reg(REG_TOL, 500);
        write_reg(REG_ACTIVE, 3);
        random_run(90);
        drain();

        write_reg(REG_LIN_GAIN, $urandom_range(0, 65535));
        write_reg(REG_HEAD_GAIN, $urandom_range(0, 65535));
        write_reg(REG_TOL, $urandom_range(0, 2000));
        write_reg(REG_ACTIVE, $urandom_range(1, 8));
        random_run(120);
        drain();

        write_reg(REG_LIN_GAIN, 4915);
        write_reg(REG_HEAD_GAIN, 11469);
        write_reg(REG_TOL, 300);
        write_reg(REG_ACTIVE, 8);
        gaps_on = 1'b0;
        random_run(140);
        drain();

        if (cmd_board.errors == 0 && cmd_board.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

`default_nettype wire

/* sim.f */
rtl/wgg_pkg.sv
rtl/wgg_ram.sv
rtl/wgg_cordic.sv
rtl/wgg_isqrt.sv
rtl/waypoint_go_to_goal_controller.sv
sim/tb_waypoint_go_to_goal_controller.sv
